// ----- hw/rtl/cscp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cycling speed and cadence packet package
// Constants, register map and sequencer states for the packet decoder.
// ----------------------------------------------------------------------------
package cscp_pkg;

    localparam int unsigned PACKET_LENGTH = 11;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [0:0]  REG_CIRC       = 1'b0;
    localparam logic [11:0] CIRC_RESET     = 12'd2170;

    localparam logic [3:0]  BYTE_CNT_MAX   = 4'd15;
    localparam logic [3:0]  BYTE_CNT_LAST  = 4'(PACKET_LENGTH - 1);
    localparam logic [3:0]  WHEEL_FIRST    = 4'd1;
    localparam logic [3:0]  WHEEL_LAST     = 4'd4;
    localparam logic [3:0]  CRANK_AFTER_WH = 4'd7;
    localparam logic [3:0]  CRANK_NO_WH    = 4'd1;

    localparam logic [15:0] CAD_SCALE      = 16'd60000;
    localparam logic [7:0]  SPEED_MAX      = 8'hFF;
    localparam logic [15:0] CAD_MAX        = 16'hFFFF;

    localparam int unsigned DIV_W          = 64;
    localparam int unsigned STEP_W         = 6;
    localparam int unsigned PROD_W         = 48;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// ----- hw/rtl/cycling_speed_cadence_packet_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cycling speed and cadence packet decoder
// Assembles measurement notifications byte by byte and computes speed and
// cadence against the previous used packet with one shared divider.
// ----------------------------------------------------------------------------
// Bytes that do not complete a packet are taken one per cycle. The final byte
// of a packet of the expected length starts a computation: one multiply and
// one divider load per result, then 64 restoring steps of the shared 64-bit
// divider, first for speed and then for cadence; the input stalls during that
// time and while the output register is full. A zero elapsed time skips the
// divider and gives the saturated result. The result sits in an output
// register, so the next packet's bytes are taken while it waits to be read.
module cycling_speed_cadence_packet_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,

    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [7:0]                           i_data_byte,
    input  wire                                  i_last_byte,
    input  wire  [31:0]                          i_now_ms,

    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [7:0]                           o_speed_kmh,
    output logic [15:0]                          o_cadence_rpm,
    output logic                                 o_zero_interval,

    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [cscp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [cscp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cscp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import cscp_pkg::*;

    t_state                r_state;
    logic [11:0]           r_circ;

    logic [3:0]            r_byte_cnt, n_byte_cnt;
    logic [1:0]            r_flags,    n_flags;
    logic [31:0]           r_wheel,    n_wheel;
    logic [15:0]           r_crank,    n_crank;
    logic [31:0]           r_prev_wheel;
    logic [15:0]           r_prev_crank;
    logic [31:0]           r_prev_time;

    logic [31:0]           r_wdiff;
    logic [15:0]           r_cdiff;
    logic [31:0]           r_delta;
    logic                  r_phase;
    logic [PROD_W-1:0]     r_prod;
    logic [DIV_W-1:0]      r_quo;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_den;
    logic [STEP_W-1:0]     r_step;

    logic [7:0]            r_speed;
    logic [15:0]           r_cad;
    logic                  r_zero;

    logic                  r_out_valid;
    logic [7:0]            r_out_speed;
    logic [15:0]           r_out_cad;
    logic                  r_out_zero;

    logic                  in_acc;
    logic                  pkt_match;
    logic                  cfg_wr;
    logic [3:0]            cnt_m1;
    logic [3:0]            crank_start;
    logic [31:0]           wdiff;
    logic [15:0]           cdiff;
    logic [31:0]           delta;
    logic [31:0]           mul_a;
    logic [15:0]           mul_b;
    logic [DIV_W-1:0]      rem_sh;
    logic [DIV_W:0]        rem_sub;
    logic                  rem_ge;
    logic [DIV_W-1:0]      quo_nxt;
    logic                  out_free;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign pkt_match    = (r_byte_cnt != BYTE_CNT_MAX) && (r_byte_cnt == BYTE_CNT_LAST);
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_CIRC) ? {20'd0, r_circ} : '0;

    assign o_out_valid     = r_out_valid;
    assign o_speed_kmh     = r_out_speed;
    assign o_cadence_rpm   = r_out_cad;
    assign o_zero_interval = r_out_zero;
    assign out_free        = !r_out_valid || !i_out_stall;

    // Byte assembly
    assign cnt_m1      = r_byte_cnt - 4'd1;
    assign crank_start = r_flags[0] ? CRANK_AFTER_WH : CRANK_NO_WH;

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_flags    = r_flags;
        n_wheel    = r_wheel;
        n_crank    = r_crank;
        if (r_byte_cnt == 4'd0) begin
            n_flags = i_data_byte[1:0];
            n_wheel = '0;
            n_crank = '0;
        end else begin
            if (r_flags[0] && r_byte_cnt >= WHEEL_FIRST && r_byte_cnt <= WHEEL_LAST) begin
                n_wheel = r_wheel | ({24'd0, i_data_byte} << {cnt_m1[1:0], 3'b000});
            end
            if (r_flags[1] && r_byte_cnt == crank_start) begin
                n_crank[7:0] = r_crank[7:0] | i_data_byte;
            end
            if (r_flags[1] && r_byte_cnt == crank_start + 4'd1) begin
                n_crank[15:8] = r_crank[15:8] | i_data_byte;
            end
        end
        if (r_byte_cnt != BYTE_CNT_MAX) begin
            n_byte_cnt = r_byte_cnt + 4'd1;
        end
    end

    assign wdiff = n_wheel - r_prev_wheel;
    assign cdiff = n_crank - r_prev_crank;
    assign delta = i_now_ms - r_prev_time;

    // Shared multiplier and divider datapath
    assign mul_a   = r_phase ? {16'd0, r_cdiff} : r_wdiff;
    assign mul_b   = r_phase ? CAD_SCALE : {4'd0, r_circ};
    assign rem_sh  = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {1'b0, r_den};
    assign rem_ge  = !rem_sub[DIV_W];
    assign quo_nxt = {r_quo[DIV_W-2:0], rem_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ <= CIRC_RESET;
        end else if (cfg_wr && paddr[2] == REG_CIRC) begin
            r_circ <= pwdata[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt   <= '0;
            r_flags      <= '0;
            r_wheel      <= '0;
            r_crank      <= '0;
            r_prev_wheel <= '0;
            r_prev_crank <= '0;
            r_prev_time  <= '0;
        end else if (in_acc) begin
            if (i_last_byte) begin
                r_byte_cnt <= '0;
                r_flags    <= '0;
                r_wheel    <= '0;
                r_crank    <= '0;
                if (pkt_match) begin
                    r_prev_wheel <= n_wheel;
                    r_prev_crank <= n_crank;
                    r_prev_time  <= i_now_ms;
                end
            end else begin
                r_byte_cnt <= n_byte_cnt;
                r_flags    <= n_flags;
                r_wheel    <= n_wheel;
                r_crank    <= n_crank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_last_byte && pkt_match) begin
                        r_phase <= 1'b0;
                        if (delta == 32'd0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == '1) begin
                        r_phase <= 1'b1;
                        r_state <= r_phase ? S_OUT : S_MUL;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_last_byte && pkt_match) begin
                    r_wdiff <= wdiff;
                    r_cdiff <= cdiff;
                    r_delta <= delta;
                    r_zero  <= (delta == 32'd0);
                    r_speed <= SPEED_MAX;
                    r_cad   <= CAD_MAX;
                end
            end
            S_MUL: begin
                r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            S_LOAD: begin
                r_rem <= '0;
                if (r_phase) begin
                    r_quo <= {16'd0, r_prod};
                    r_den <= {32'd0, r_delta};
                end else begin
                    r_quo <= ({16'd0, r_prod} << 5) + ({16'd0, r_prod} << 2);
                    r_den <= ({32'd0, r_delta} << 3) + ({32'd0, r_delta} << 1);
                end
            end
            S_DIV: begin
                r_rem <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh;
                r_quo <= quo_nxt;
                if (r_step == '1) begin
                    if (r_phase) begin
                        r_cad <= (quo_nxt > DIV_W'(CAD_MAX)) ? CAD_MAX : quo_nxt[15:0];
                    end else begin
                        r_speed <= (quo_nxt > DIV_W'(SPEED_MAX)) ? SPEED_MAX : quo_nxt[7:0];
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_speed <= r_speed;
                    r_out_cad   <= r_cad;
                    r_out_zero  <= r_zero;
                end
            end
            default: begin
            end
        endcase
    end

    a_zero_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_interval) |->
            (o_speed_kmh == SPEED_MAX && o_cadence_rpm == CAD_MAX))
        else $error("zero interval result not saturated");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

    a_start_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte && pkt_match && delta != 32'd0) |=> (r_state == S_MUL))
        else $error("used packet did not start the computation");

endmodule
`default_nettype wire

// ----- verif/cycling_speed_cadence_packet_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycling speed and cadence packet decoder testbench
// Streams measurement notifications into the decoder byte by byte. Packets are
// well formed, short or overlong, with random flags and content. A scoreboard
// decodes each accepted byte itself and queues the speed and cadence readings
// it expects. Both handshakes idle at random, the receiver holds off for a long
// stretch once, and the wheel circumference is changed between phases.
// ----------------------------------------------------------------------------
module cycling_speed_cadence_packet_top_tb;
    import cscp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned IDLE_PERCENT  = 25;
    localparam int unsigned MAX_PKT_BYTES = 20;
    localparam logic [11:0] WHEEL_MM_MIN  = 12'd1000;
    localparam logic [11:0] WHEEL_MM_MAX  = 12'd3000;
    localparam logic [63:0] KMH_NUM       = 64'd36;
    localparam logic [63:0] KMH_DEN       = 64'd10;
    localparam int unsigned FLAG_WHEEL    = 0;
    localparam int unsigned FLAG_CRANK    = 1;
    localparam logic [APB_ADDR_W-1:0] CIRC_ADDR = APB_ADDR_W'(int'(REG_CIRC) * 4);

    typedef struct packed {
        logic [7:0]  speed_kmh;
        logic [15:0] cadence_rpm;
        logic        zero_interval;
    } t_reading;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    wire                   in_stall;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic [31:0]           now_ms;
    wire                   out_valid;
    logic                  out_stall;
    wire  [7:0]            speed_kmh;
    wire  [15:0]           cadence_rpm;
    wire                   zero_interval;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    // scoreboard copy of the decoder state
    logic [11:0] circ_mm;
    logic [3:0]  pkt_bytes;
    logic [1:0]  pkt_flags;
    logic [31:0] pkt_wheel;
    logic [15:0] pkt_crank;
    logic [31:0] last_wheel;
    logic [15:0] last_crank;
    logic [31:0] last_ms;
    t_reading    pending_readings[$];

    // rolling sensor values for generated packets
    logic [31:0] sensor_wheel;
    logic [15:0] sensor_crank;
    logic [31:0] sensor_ms;

    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned errors      = 0;
    logic        quiet       = 1'b0;
    logic        hold_active = 1'b0;
    event        receiver_hold;

    cycling_speed_cadence_packet_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_last_byte     (last_byte),
        .i_now_ms        (now_ms),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_speed_kmh     (speed_kmh),
        .o_cadence_rpm   (cadence_rpm),
        .o_zero_interval (zero_interval),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cycling_speed_cadence_packet_top_tb: errors");
            $finish;
        end
    end

    // fold one byte into the packet and queue the reading it completes
    function automatic void decode_measurement_byte(input logic [7:0] b, input logic lst,
                                                    input logic [31:0] now);
        logic        complete;
        logic [3:0]  crank_first;
        logic [31:0] delta;
        logic [31:0] wheel_diff;
        logic [15:0] crank_diff;
        logic [63:0] quotient;
        t_reading    r;
        complete = (pkt_bytes == 4'(PACKET_LENGTH - 1));
        if (pkt_bytes == 4'd0) begin
            pkt_flags = b[1:0];
            pkt_wheel = '0;
            pkt_crank = '0;
        end else begin
            crank_first = pkt_flags[FLAG_WHEEL] ? CRANK_AFTER_WH : CRANK_NO_WH;
            if (pkt_flags[FLAG_WHEEL] && pkt_bytes >= WHEEL_FIRST && pkt_bytes <= WHEEL_LAST)
                pkt_wheel = pkt_wheel | (32'(b) << (8 * (pkt_bytes - WHEEL_FIRST)));
            if (pkt_flags[FLAG_CRANK] && pkt_bytes >= crank_first
                    && pkt_bytes <= crank_first + 4'd1)
                pkt_crank = pkt_crank | (16'(b) << (8 * (pkt_bytes - crank_first)));
        end
        if (pkt_bytes != BYTE_CNT_MAX)
            pkt_bytes = pkt_bytes + 4'd1;
        if (!lst)
            return;
        if (complete) begin
            delta      = now - last_ms;
            wheel_diff = pkt_wheel - last_wheel;
            crank_diff = pkt_crank - last_crank;
            if (delta == 32'd0) begin
                r = '{SPEED_MAX, CAD_MAX, 1'b1};
            end else begin
                quotient = (64'(wheel_diff) * 64'(circ_mm) * KMH_NUM) / (64'(delta) * KMH_DEN);
                r.speed_kmh = (quotient > 64'(SPEED_MAX)) ? SPEED_MAX : quotient[7:0];
                quotient = (64'(crank_diff) * 64'(CAD_SCALE)) / 64'(delta);
                r.cadence_rpm = (quotient > 64'(CAD_MAX)) ? CAD_MAX : quotient[15:0];
                r.zero_interval = 1'b0;
            end
            pending_readings.push_back(r);
            last_wheel = pkt_wheel;
            last_crank = pkt_crank;
            last_ms    = now;
        end
        pkt_bytes = '0;
        pkt_flags = '0;
        pkt_wheel = '0;
        pkt_crank = '0;
    endfunction

    always @(posedge clk) begin : receive_readings
        t_reading want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_readings.size() == 0) begin
                $error("reading with none expected: speed_kmh %0d cadence_rpm %0d zero_interval %0d",
                       speed_kmh, cadence_rpm, zero_interval);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (speed_kmh !== want.speed_kmh) begin
                    $error("speed_kmh: expected %0d, actual %0d", want.speed_kmh, speed_kmh);
                    errors++;
                end
                if (cadence_rpm !== want.cadence_rpm) begin
                    $error("cadence_rpm: expected %0d, actual %0d", want.cadence_rpm, cadence_rpm);
                    errors++;
                end
                if (zero_interval !== want.zero_interval) begin
                    $error("zero_interval: expected %0d, actual %0d",
                           want.zero_interval, zero_interval);
                    errors++;
                end
            end
        end
        out_stall <= hold_active || (!quiet && $urandom_range(99) < IDLE_PERCENT);
    end

    // hold the output for a long stretch
    always begin
        @(receiver_hold);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] now);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        now_ms    <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        decode_measurement_byte(b, lst, now);
        bytes_sent++;
    endtask

    task automatic send_packet(input int len, input logic [7:0] flags_byte,
                               input logic [31:0] wheel, input logic [15:0] crank,
                               input logic [31:0] now);
        logic [7:0] pkt [MAX_PKT_BYTES];
        int         crank_at;
        for (int i = 0; i < MAX_PKT_BYTES; i++)
            pkt[i] = 8'($urandom);
        pkt[0] = flags_byte;
        if (flags_byte[FLAG_WHEEL])
            for (int i = 0; i < 4; i++)
                pkt[int'(WHEEL_FIRST) + i] = wheel[8*i +: 8];
        crank_at = flags_byte[FLAG_WHEEL] ? int'(CRANK_AFTER_WH) : int'(CRANK_NO_WH);
        if (flags_byte[FLAG_CRANK])
            for (int i = 0; i < 2; i++)
                pkt[crank_at + i] = crank[8*i +: 8];
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], i == len - 1, (i == len - 1) ? now : 32'($urandom));
    endtask

    task automatic send_random_packet();
        int len;
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(9))
                0:       sensor_wheel = $urandom;
                1:       sensor_wheel = sensor_wheel - $urandom_range(1, 30);
                default: sensor_wheel = sensor_wheel + $urandom_range(0, 30);
            endcase
            case ($urandom_range(9))
                0:       sensor_crank = 16'($urandom);
                1:       sensor_crank = sensor_crank - 16'($urandom_range(1, 5));
                default: sensor_crank = sensor_crank + 16'($urandom_range(0, 5));
            endcase
            case ($urandom_range(9))
                0:       sensor_ms = sensor_ms;
                1:       sensor_ms = $urandom;
                2:       sensor_ms = sensor_ms + $urandom_range(1, 20);
                default: sensor_ms = sensor_ms + $urandom_range(200, 3000);
            endcase
            send_packet(PACKET_LENGTH, 8'($urandom), sensor_wheel, sensor_crank, sensor_ms);
        end else begin
            len = $urandom_range(1, MAX_PKT_BYTES - 1);
            if (len >= PACKET_LENGTH)
                len++;
            send_packet(len, 8'($urandom), $urandom, 16'($urandom), $urandom);
        end
    endtask

    task automatic send_random_packets(input int unsigned count);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_packet();
    endtask

    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
    endtask

    task automatic settle_block();
        wait_for_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_circumference(input logic [11:0] mm);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CIRC_ADDR;
        pwdata  <= APB_DATA_W'(mm);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        circ_mm = mm;
    endtask

    task automatic test_extremes();
        send_packet(PACKET_LENGTH, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_interval();
        send_packet(PACKET_LENGTH, 8'h00, '0, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_short_packet();
        send_packet(2, 8'h03, $urandom, 16'($urandom), $urandom);
    endtask

    task automatic test_random_readings();
        send_random_packets(300);
    endtask

    task automatic test_backpressure();
        -> receiver_hold;
        send_random_packets(110);
        wait_for_readings();
        send_random_packets(50);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        send_random_packets(150);
        quiet = 1'b0;
    endtask

    task automatic test_circumference_settings();
        logic [11:0] settings [4];
        settings = '{WHEEL_MM_MAX, WHEEL_MM_MIN,
                     12'($urandom_range(WHEEL_MM_MIN, WHEEL_MM_MAX)), CIRC_RESET};
        foreach (settings[i]) begin
            settle_block();
            write_circumference(settings[i]);
            send_random_packets(300);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = '0;
        last_byte    = 1'b0;
        now_ms       = '0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        circ_mm      = CIRC_RESET;
        pkt_bytes    = '0;
        pkt_flags    = '0;
        pkt_wheel    = '0;
        pkt_crank    = '0;
        last_wheel   = '0;
        last_crank   = '0;
        last_ms      = '0;
        sensor_wheel = $urandom;
        sensor_crank = 16'($urandom);
        sensor_ms    = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_zero_interval();
        test_short_packet();
        test_random_readings();
        test_backpressure();
        test_back_to_back();
        test_circumference_settings();

        settle_block();
        if (errors == 0) begin
            $display("cycling_speed_cadence_packet_top_tb: clean");
        end else begin
            $display("cycling_speed_cadence_packet_top_tb: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cscp_pkg.sv
hw/rtl/cycling_speed_cadence_packet_top.sv
verif/cycling_speed_cadence_packet_top_tb.sv
